// ===== rtl/ptl_pkg.sv =====
// Package with the shared types and constants of the peer table.
`timescale 1ns / 1ps
package ptl_pkg;

  localparam int unsigned Depth   = 64;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned CntW    = 7;

  localparam logic [1:0] ActInsert   = 2'd0;
  localparam logic [1:0] ActQueryRtt = 2'd1;
  localparam logic [1:0] ActQueryId  = 2'd2;
  localparam logic [1:0] ActReserved = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StWait,
    StDecide,
    StScan2,
    StWait2,
    StDone
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;      // capture the input word
    logic            scan_clr;  // clear scan results (all of them only with load), restart the index
    logic            scan_en;   // read entry at the scan index
    logic            age_pass;  // second pass: search for oldest touch only
    logic            commit;    // apply the update and register the result
  } ptl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;     // last entry issued
    logic need_second;   // a limit eviction needs a fresh age search
  } ptl_sts_t;

endpackage

// ===== rtl/ptl_ram.sv =====
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
module ptl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write through one port, read registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/ptl_ctrl.sv =====
// Controller state machine that sequences the table scans.
`timescale 1ns / 1ps
module ptl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ptl_pkg::ptl_sts_t sts,
  output ptl_pkg::ptl_cmd_t cmd,
  output logic              busy
);

  ptl_pkg::ctl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptl_pkg::StIdle;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ptl_pkg::StIdle: begin
        busy = 1'b0;
        if (start) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = ptl_pkg::StScan;
        end
      end
      ptl_pkg::StScan: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_last) begin
          state_next = ptl_pkg::StWait;
        end
      end
      ptl_pkg::StWait: begin
        state_next = ptl_pkg::StDecide;
      end
      ptl_pkg::StDecide: begin
        cmd.commit = 1'b1;
        if (sts.need_second) begin
          cmd.scan_clr = 1'b1;
          state_next   = ptl_pkg::StScan2;
        end else begin
          state_next = ptl_pkg::StDone;
        end
      end
      ptl_pkg::StScan2: begin
        cmd.scan_en  = 1'b1;
        cmd.age_pass = 1'b1;
        if (sts.scan_last) begin
          state_next = ptl_pkg::StWait2;
        end
      end
      ptl_pkg::StWait2: begin
        cmd.age_pass = 1'b1;
        state_next   = ptl_pkg::StDone;
      end
      ptl_pkg::StDone: begin
        cmd.age_pass = 1'b1;
        state_next   = ptl_pkg::StIdle;
      end
      default: begin
        state_next = ptl_pkg::StIdle;
      end
    endcase
  end

endmodule

// ===== rtl/ptl_dp.sv =====
// Datapath: entry memories, valid bits, scan compare and update logic.
`timescale 1ns / 1ps
module ptl_dp (
  input  logic                clk,
  input  logic                rst,
  input  ptl_pkg::ptl_cmd_t   cmd,
  output ptl_pkg::ptl_sts_t   sts,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_data,
  input  logic [1:0]          action,
  input  logic [31:0]         ip_addr,
  input  logic [15:0]         port,
  input  logic signed [31:0]  session,
  input  logic [30:0]         peer_id,
  input  logic [23:0]         rtt_sample,
  output logic signed [31:0]  value,
  output logic                found,
  output logic                evicted,
  output logic                strobe
);

  localparam int unsigned IdxW = ptl_pkg::IdxW;
  localparam int unsigned CntW = ptl_pkg::CntW;
  localparam int unsigned KeyW = 80;

  // Captured input word.
  logic [1:0]  act_q;
  logic [31:0] addr_q;
  logic [15:0] port_q;
  logic [31:0] sess_q;
  logic [30:0] id_q;
  logic [23:0] rtt_q;

  logic [6:0]        record_limit;
  logic [ptl_pkg::Depth-1:0] valid;
  logic [31:0]       stamp;
  logic [CntW-1:0]   count;

  // Scan index and the delayed index matching the read data.
  logic [IdxW:0]     scan_idx;
  logic [IdxW-1:0]   rd_idx;
  logic              rd_vld;

  // Scan results.
  logic              hit;
  logic [IdxW-1:0]   hit_idx;
  logic [30:0]       hit_id;
  logic [23:0]       hit_rtt;
  logic              any_free;
  logic [IdxW-1:0]   free_idx;
  logic              old_vld;
  logic [IdxW-1:0]   old_idx;
  logic [31:0]       old_age;
  logic              aged_vld;
  logic [31:0]       best_age;
  logic [23:0]       best_rtt;
  logic              second;
  logic              strobe_pend;

  // Memory ports.
  logic              we;
  logic [IdxW-1:0]   ram_addr;
  logic [KeyW-1:0]   key_wd, key_rd;
  logic [30:0]       id_wd, id_rd;
  logic [23:0]       rtt_wd, rtt_rd;
  logic [31:0]       ts_wd, ts_rd, is_rd;
  logic              is_we;

  logic [26:0]       ewma;
  logic [31:0]       age_t, age_i;
  logic              key_eq, addr_eq, entry_ok;

  ptl_ram #(.Width(KeyW), .Depth(ptl_pkg::Depth)) u_key (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(key_wd), .rdata(key_rd));
  ptl_ram #(.Width(31), .Depth(ptl_pkg::Depth)) u_id (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(id_wd), .rdata(id_rd));
  ptl_ram #(.Width(24), .Depth(ptl_pkg::Depth)) u_rtt (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(rtt_wd), .rdata(rtt_rd));
  ptl_ram #(.Width(32), .Depth(ptl_pkg::Depth)) u_ts (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(ts_wd), .rdata(ts_rd));
  ptl_ram #(.Width(32), .Depth(ptl_pkg::Depth)) u_is (
    .clk(clk), .we(is_we), .addr(ram_addr), .wdata(stamp), .rdata(is_rd));

  // Compare of the entry read in the previous cycle. In the second age search
  // the stamp has already advanced, so the new entry counts as youngest.
  assign entry_ok = rd_vld && valid[rd_idx];
  assign addr_eq  = key_rd[79:48] == addr_q;
  assign key_eq   = key_rd == {addr_q, port_q, sess_q};
  assign age_t    = stamp - ts_rd;
  assign age_i    = stamp - is_rd;
  assign ewma     = ({3'd0, hit_rtt} * 27'd7 + {3'd0, rtt_q}) >> 3;

  // Slot that the commit writes, and whether it creates an entry.
  logic [IdxW-1:0] wr_slot;
  logic            create;
  assign create  = act_q == ptl_pkg::ActInsert && !hit;
  assign wr_slot = hit ? hit_idx : (any_free ? free_idx : old_idx);
  assign we      = cmd.commit && act_q == ptl_pkg::ActInsert;
  assign is_we   = we && create;
  assign ram_addr = cmd.commit ? wr_slot : scan_idx[IdxW-1:0];

  // Write data: a hit keeps its key and updates id and rtt.
  always_comb begin
    key_wd = {addr_q, port_q, sess_q};
    ts_wd  = stamp;
    if (hit) begin
      id_wd  = (id_q != '0) ? id_q : hit_id;
      rtt_wd = (rtt_q == '0) ? hit_rtt : ((hit_rtt == '0) ? rtt_q : ewma[23:0]);
    end else begin
      id_wd  = id_q;
      rtt_wd = rtt_q;
    end
  end

  assign sts.scan_last   = scan_idx[IdxW-1:0] == IdxW'(ptl_pkg::Depth - 1) && !scan_idx[IdxW];
  assign sts.need_second = create && any_free && (count + 1'b1 > record_limit);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      record_limit <= 7'd64;
    end else if (cfg_we) begin
      record_limit <= cfg_data;
    end
  end

  // Input capture, scan bookkeeping and table update.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      stamp       <= '0;
      count       <= '0;
      strobe      <= 1'b0;
      strobe_pend <= 1'b0;
      second      <= 1'b0;
      rd_vld      <= 1'b0;
      scan_idx    <= '0;
    end else begin
      strobe <= 1'b0;
      rd_vld <= cmd.scan_en;
      rd_idx <= scan_idx[IdxW-1:0];
      if (cmd.load) begin
        act_q  <= action;
        addr_q <= ip_addr;
        port_q <= port;
        sess_q <= session;
        id_q   <= peer_id;
        rtt_q  <= rtt_sample;
        second <= 1'b0;
      end
      if (cmd.scan_clr) begin
        scan_idx <= '0;
        old_vld  <= 1'b0;
        old_age  <= '0;
        if (cmd.load) begin
          hit      <= 1'b0;
          any_free <= 1'b0;
          aged_vld <= 1'b0;
          found    <= 1'b0;
        end
      end else if (cmd.scan_en) begin
        scan_idx <= scan_idx + 1'b1;
      end
      // Accumulate results of the entry just read.
      if (rd_vld) begin
        if (!entry_ok && !any_free && !cmd.age_pass) begin
          any_free <= 1'b1;
          free_idx <= rd_idx;
        end
        if (entry_ok && (!old_vld || age_t > old_age)) begin
          old_vld <= 1'b1;
          old_idx <= rd_idx;
          old_age <= age_t;
        end
        if (entry_ok && !cmd.age_pass) begin
          if (key_eq && !hit) begin
            hit     <= 1'b1;
            hit_idx <= rd_idx;
            hit_id  <= id_rd;
            hit_rtt <= rtt_rd;
          end
          if (addr_eq && rtt_rd != '0 && (!aged_vld || age_i > best_age)) begin
            aged_vld <= 1'b1;
            best_age <= age_i;
            best_rtt <= rtt_rd;
          end
        end
      end
      // Commit: update state and form the result.
      if (cmd.commit) begin
        value   <= -32'sd1;
        evicted <= 1'b0;
        unique case (act_q)
          ptl_pkg::ActInsert: begin
            value <= '0;
            found <= hit;
            stamp <= stamp + 1'b1;
            if (create) begin
              valid[wr_slot] <= 1'b1;
              if (any_free) begin
                count <= count + 1'b1;
              end else begin
                evicted <= 1'b1;
              end
            end
          end
          ptl_pkg::ActQueryRtt: begin
            // Found was gathered during the scan.
            if (aged_vld) begin
              value <= {8'd0, best_rtt};
            end
          end
          ptl_pkg::ActQueryId: begin
            found <= hit;
            if (hit && hit_id != '0) begin
              value <= {1'b0, hit_id};
            end
          end
          default: begin
            found <= 1'b0;
          end
        endcase
        if (sts.need_second) begin
          second      <= 1'b1;
          strobe_pend <= 1'b1;
        end else begin
          strobe <= 1'b1;
        end
      end
      // Query rtt: found means the address is present at all.
      if (rd_vld && entry_ok && addr_eq && act_q == ptl_pkg::ActQueryRtt) begin
        found <= 1'b1;
      end
      // Limit eviction after the second age search; the stamp already moved on.
      if (strobe_pend && !cmd.scan_en && !rd_vld && cmd.age_pass && !second) begin
        strobe_pend <= 1'b0;
      end
      if (second && cmd.age_pass && !rd_vld && !cmd.scan_en && strobe_pend) begin
        valid[old_idx] <= 1'b0;
        count          <= count - 1'b1;
        evicted        <= 1'b1;
        strobe         <= 1'b1;
        strobe_pend    <= 1'b0;
        second         <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/peer_table_lru_ewma_rtt_top.sv =====
// Top level of the peer table with least-recently-touched eviction.
`timescale 1ns / 1ps
// One word is taken when start is high and busy is low; its result is on
// value, found and evicted with strobe high for exactly one cycle. The
// receiver cannot stall it. Each word is done before the next is taken: a
// scan of all 64 entries through the registered read of the entry RAMs,
// then the wait, decide and done states; an insert that creates an entry
// beyond record_limit takes a second scan for the oldest entry before its
// result is given and the next word is taken.
// No clearing pass follows reset.
module peer_table_lru_ewma_rtt_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [31:0]        ip_addr,
  input  logic [15:0]        port,
  input  logic signed [31:0] session,
  input  logic [30:0]        peer_id,
  input  logic [23:0]        rtt_sample,
  output logic signed [31:0] value,
  output logic               found,
  output logic               evicted,
  output logic               strobe,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  ptl_pkg::ptl_cmd_t cmd;
  ptl_pkg::ptl_sts_t sts;
  logic              ctl_busy;

  assign cfg_ready = 1'b1;
  assign busy      = ctl_busy;

  ptl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(ctl_busy));

  ptl_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .action(action), .ip_addr(ip_addr), .port(port), .session(session),
    .peer_id(peer_id), .rtt_sample(rtt_sample),
    .value(value), .found(found), .evicted(evicted), .strobe(strobe));

  // No result strobe in the cycle after a reset cycle.
  a_no_strobe_reset: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe after reset");
  // A taken word makes the block busy next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after start");
  // Strobe is a single-cycle pulse.
  a_strobe_pulse: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("strobe held");

endmodule
